@@ rtl/mlfp_pkg.sv @@
// Shared types, constants and the CRC-8 helper for the MSP/LTM frame parser.
package mlfp_pkg;

    // Largest MSP payload the input buffer holds, in bytes
    localparam logic [15:0] INBUF_SIZE = 16'd256;

    // LTM payload lengths per frame type
    localparam logic [4:0] LTM_A_LEN = 5'd6;
    localparam logic [4:0] LTM_G_LEN = 5'd14;
    localparam logic [4:0] LTM_S_LEN = 5'd7;

    // Framing characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;   // '$'
    localparam logic [7:0] CH_M      = 8'h4D;   // 'M'
    localparam logic [7:0] CH_X      = 8'h58;   // 'X'
    localparam logic [7:0] CH_T      = 8'h54;   // 'T'
    localparam logic [7:0] CH_GT     = 8'h3E;   // '>'
    localparam logic [7:0] CH_A      = 8'h41;   // 'A'
    localparam logic [7:0] CH_G      = 8'h47;   // 'G'
    localparam logic [7:0] CH_N      = 8'h4E;   // 'N'
    localparam logic [7:0] CH_O      = 8'h4F;   // 'O'
    localparam logic [7:0] CH_S      = 8'h53;   // 'S'

    // v1 command that tunnels a v2 frame, and the least v1 size it needs
    localparam logic [7:0]  TUNNEL_CMD      = 8'hFF;
    localparam logic [15:0] TUNNEL_MIN_SIZE = 16'd6;

    // CRC-8 DVB-S2 polynomial
    localparam logic [7:0] CRC8_POLY = 8'hD5;

    // Buffer targets / frame kinds
    localparam logic TGT_MSP = 1'b0;
    localparam logic TGT_LTM = 1'b1;

    // MSP version codes
    localparam logic [1:0] MSP_V1     = 2'd0;
    localparam logic [1:0] MSP_V2_TUN = 2'd1;
    localparam logic [1:0] MSP_V2_NAT = 2'd2;

    // LTM type codes
    localparam logic [2:0] LTM_KIND_A = 3'd0;
    localparam logic [2:0] LTM_KIND_G = 3'd1;
    localparam logic [2:0] LTM_KIND_N = 3'd2;
    localparam logic [2:0] LTM_KIND_O = 3'd3;
    localparam logic [2:0] LTM_KIND_S = 3'd4;
    localparam logic [2:0] LTM_KIND_X = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'd0,
        ST_START   = 4'd1,
        ST_LTM_HDR = 4'd2,
        ST_LTM_PAY = 4'd3,
        ST_LTM_CK  = 4'd4,
        ST_M       = 4'd5,
        ST_X       = 4'd6,
        ST_V1_HDR  = 4'd7,
        ST_V1_PAY  = 4'd8,
        ST_V1_CK   = 4'd9,
        ST_TUN_HDR = 4'd10,
        ST_TUN_PAY = 4'd11,
        ST_TUN_CK  = 4'd12,
        ST_NAT_HDR = 4'd13,
        ST_NAT_PAY = 4'd14,
        ST_NAT_CK  = 4'd15
    } parser_state_t;

    // One result word
    typedef struct packed {
        logic        accepted;
        logic        store_valid;
        logic        store_target;
        logic [7:0]  store_index;
        logic [7:0]  store_byte;
        logic        frame_done;
        logic        frame_kind;
        logic [1:0]  msp_version;
        logic [15:0] command;
        logic [7:0]  cmd_flags;
        logic [8:0]  payload_size;
        logic [2:0]  ltm_frame_type;
    } result_t;

    // One byte of CRC-8 DVB-S2, MSB first, init handled by caller
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC8_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/msp_ltm_frame_parser.sv @@
// Byte-serial parser for MSP v1, MSP v2 (tunneled and native) and LTM telemetry frames.

// The parser takes one received byte per word on the slave stream and returns
// one result word per byte on the master stream: whether the byte was taken
// into a frame, the buffer write it causes (target, index, value) and, on the
// byte that closes a frame with a good check, frame_done with the frame's
// version, command, flags and size or its LTM type. A byte is accepted every
// cycle while the result register is empty or being drained; the result appears
// in the cycle after its byte, and the single output register sets that rate.
// Bad header bytes, oversize lengths and failed checks send the parser back to idle.
module msp_ltm_frame_parser (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] accepted, [1] store_valid, [9:2] store_index, [17:10] store_byte,
    // [18] frame_done, [20:19] msp_version, [36:21] command, [44:37] cmd_flags,
    // [53:45] payload_size, [56:54] ltm_frame_type, [63:57] zero
    output logic [63:0] m_axis_tdata,
    // [0] store_target, [1] frame_kind
    output logic [1:0]  m_axis_tuser
);
    import mlfp_pkg::*;

    parser_state_t state_reg, state_next;
    logic [1:0]    version_reg, version_next;
    logic [7:0]    xor_sum_reg, xor_sum_next;
    logic [7:0]    crc_sum_reg, crc_sum_next;
    logic [15:0]   byte_offset_reg, byte_offset_next;
    logic [15:0]   expected_size_reg, expected_size_next;
    logic [15:0]   command_reg, command_next;
    logic [7:0]    flags_reg, flags_next;
    logic [2:0]    ltm_kind_reg, ltm_kind_next;
    logic [4:0]    ltm_count_reg, ltm_count_next;

    // Header bytes of the current frame; the last header byte is used live
    logic [7:0]    hdr_mem [0:5];
    logic          hdr_we;

    logic          out_valid_reg;
    result_t       result_reg;
    result_t       res;

    logic          in_accept;
    logic [7:0]    b;
    logic [15:0]   off_inc;
    logic [7:0]    crc_new;
    logic [4:0]    cnt_inc;
    logic [4:0]    ltm_len;
    logic [15:0]   size;

    // Handshake: take a byte whenever the result register is free or draining
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign b       = s_axis_tdata;
    assign off_inc = byte_offset_reg + 16'd1;
    assign crc_new = crc8_step(crc_sum_reg, b);
    assign cnt_inc = ltm_count_reg + 5'd1;

    // LTM payload length for the current type
    always_comb
    begin
        case (ltm_kind_reg)
            LTM_KIND_G, LTM_KIND_O: ltm_len = LTM_G_LEN;
            LTM_KIND_S:             ltm_len = LTM_S_LEN;
            default:                ltm_len = LTM_A_LEN;
        endcase
    end

    // Next state and result for the byte at the input
    always_comb
    begin
        state_next         = state_reg;
        version_next       = version_reg;
        xor_sum_next       = xor_sum_reg;
        crc_sum_next       = crc_sum_reg;
        byte_offset_next   = byte_offset_reg;
        expected_size_next = expected_size_reg;
        command_next       = command_reg;
        flags_next         = flags_reg;
        ltm_kind_next      = ltm_kind_reg;
        ltm_count_next     = ltm_count_reg;
        hdr_we             = 1'b0;
        size               = 16'd0;
        res                = '0;
        res.accepted       = 1'b1;

        unique case (state_reg)
            ST_START:
            begin
                if (b == CH_M) begin
                    state_next = ST_M;
                end else if (b == CH_X) begin
                    state_next = ST_X;
                end else if (b == CH_T) begin
                    state_next       = ST_LTM_HDR;
                    res.store_valid  = 1'b1;
                    res.store_target = TGT_LTM;
                    res.store_index  = 8'd1;
                    res.store_byte   = b;
                end else begin
                    state_next = ST_IDLE;
                end
            end

            ST_LTM_HDR:
            begin
                state_next = ST_LTM_PAY;
                case (b)
                    CH_A:    ltm_kind_next = LTM_KIND_A;
                    CH_G:    ltm_kind_next = LTM_KIND_G;
                    CH_N:    ltm_kind_next = LTM_KIND_N;
                    CH_O:    ltm_kind_next = LTM_KIND_O;
                    CH_S:    ltm_kind_next = LTM_KIND_S;
                    CH_X:    ltm_kind_next = LTM_KIND_X;
                    default: state_next    = ST_IDLE;
                endcase
                res.store_valid  = 1'b1;
                res.store_target = TGT_LTM;
                res.store_index  = 8'd2;
                res.store_byte   = b;
                ltm_count_next   = 5'd0;
            end

            ST_LTM_PAY:
            begin
                ltm_count_next   = cnt_inc;
                res.store_valid  = 1'b1;
                res.store_target = TGT_LTM;
                res.store_index  = 8'd2 + {3'd0, cnt_inc};
                res.store_byte   = b;
                xor_sum_next     = xor_sum_reg ^ b;
                if (cnt_inc == ltm_len) begin
                    state_next = ST_LTM_CK;
                end
            end

            ST_LTM_CK:
            begin
                res.store_valid  = 1'b1;
                res.store_target = TGT_LTM;
                res.store_index  = 8'd3 + {3'd0, ltm_count_reg};
                res.store_byte   = b;
                if (xor_sum_reg == b) begin
                    res.frame_done     = 1'b1;
                    res.frame_kind     = TGT_LTM;
                    res.ltm_frame_type = ltm_kind_reg;
                end
                state_next = ST_IDLE;
            end

            ST_M:
            begin
                if (b == CH_GT) begin
                    byte_offset_next = 16'd0;
                    xor_sum_next     = 8'd0;
                    crc_sum_next     = 8'd0;
                    state_next       = ST_V1_HDR;
                end else begin
                    state_next = ST_IDLE;
                end
            end

            ST_X:
            begin
                if (b == CH_GT) begin
                    byte_offset_next = 16'd0;
                    crc_sum_next     = 8'd0;
                    version_next     = MSP_V2_NAT;
                    state_next       = ST_NAT_HDR;
                end else begin
                    state_next = ST_IDLE;
                end
            end

            ST_V1_HDR:
            begin
                res.store_valid  = 1'b1;
                res.store_index  = byte_offset_reg[7:0];
                res.store_byte   = b;
                hdr_we           = 1'b1;
                byte_offset_next = off_inc;
                xor_sum_next     = xor_sum_reg ^ b;
                // size, cmd complete
                if (off_inc == 16'd2) begin
                    size = {8'd0, hdr_mem[0]};
                    if (size > INBUF_SIZE) begin
                        state_next = ST_IDLE;
                    end else if (b == TUNNEL_CMD) begin
                        if (size >= TUNNEL_MIN_SIZE) begin
                            version_next = MSP_V2_TUN;
                            state_next   = ST_TUN_HDR;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        expected_size_next = size;
                        command_next       = {8'd0, b};
                        flags_next         = 8'd0;
                        byte_offset_next   = 16'd0;
                        state_next         = (size != 16'd0) ? ST_V1_PAY : ST_V1_CK;
                    end
                end
            end

            ST_V1_PAY:
            begin
                xor_sum_next     = xor_sum_reg ^ b;
                res.store_valid  = 1'b1;
                res.store_index  = byte_offset_reg[7:0];
                res.store_byte   = b;
                byte_offset_next = off_inc;
                if (off_inc == expected_size_reg) begin
                    state_next = ST_V1_CK;
                end
            end

            ST_V1_CK:
            begin
                if (xor_sum_reg == b) begin
                    res.frame_done   = 1'b1;
                    res.frame_kind   = TGT_MSP;
                    res.msp_version  = version_reg;
                    res.command      = command_reg;
                    res.cmd_flags    = flags_reg;
                    res.payload_size = expected_size_reg[8:0];
                end
                state_next = ST_IDLE;
            end

            ST_TUN_HDR:
            begin
                res.store_valid  = 1'b1;
                res.store_index  = byte_offset_reg[7:0];
                res.store_byte   = b;
                hdr_we           = 1'b1;
                byte_offset_next = off_inc;
                xor_sum_next     = xor_sum_reg ^ b;
                crc_sum_next     = crc_new;
                // flags, cmd16, size16 complete after the v1 header
                if (off_inc == 16'd7) begin
                    size               = {b, hdr_mem[5]};
                    expected_size_next = size;
                    if (size > INBUF_SIZE) begin
                        state_next = ST_IDLE;
                    end else begin
                        command_next     = {hdr_mem[4], hdr_mem[3]};
                        flags_next       = hdr_mem[2];
                        byte_offset_next = 16'd0;
                        state_next       = (size != 16'd0) ? ST_TUN_PAY : ST_TUN_CK;
                    end
                end
            end

            ST_TUN_PAY:
            begin
                crc_sum_next     = crc_new;
                xor_sum_next     = xor_sum_reg ^ b;
                res.store_valid  = 1'b1;
                res.store_index  = byte_offset_reg[7:0];
                res.store_byte   = b;
                byte_offset_next = off_inc;
                if (off_inc == expected_size_reg) begin
                    state_next = ST_TUN_CK;
                end
            end

            ST_TUN_CK:
            begin
                // inner crc, folded into the outer xor that follows
                xor_sum_next = xor_sum_reg ^ b;
                state_next   = (crc_sum_reg == b) ? ST_V1_CK : ST_IDLE;
            end

            ST_NAT_HDR:
            begin
                res.store_valid  = 1'b1;
                res.store_index  = byte_offset_reg[7:0];
                res.store_byte   = b;
                hdr_we           = 1'b1;
                byte_offset_next = off_inc;
                crc_sum_next     = crc_new;
                if (off_inc == 16'd5) begin
                    size               = {b, hdr_mem[3]};
                    expected_size_next = size;
                    if (size > INBUF_SIZE) begin
                        state_next = ST_IDLE;
                    end else begin
                        command_next     = {hdr_mem[2], hdr_mem[1]};
                        flags_next       = hdr_mem[0];
                        byte_offset_next = 16'd0;
                        state_next       = (size != 16'd0) ? ST_NAT_PAY : ST_NAT_CK;
                    end
                end
            end

            ST_NAT_PAY:
            begin
                crc_sum_next     = crc_new;
                res.store_valid  = 1'b1;
                res.store_index  = byte_offset_reg[7:0];
                res.store_byte   = b;
                byte_offset_next = off_inc;
                if (off_inc == expected_size_reg) begin
                    state_next = ST_NAT_CK;
                end
            end

            ST_NAT_CK:
            begin
                if (crc_sum_reg == b) begin
                    res.frame_done   = 1'b1;
                    res.frame_kind   = TGT_MSP;
                    res.msp_version  = version_reg;
                    res.command      = command_reg;
                    res.cmd_flags    = flags_reg;
                    res.payload_size = expected_size_reg[8:0];
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                // idle: hunt for frame start
                state_next = ST_IDLE;
                if (b == CH_DOLLAR) begin
                    version_next     = MSP_V1;
                    state_next       = ST_START;
                    res.store_valid  = 1'b1;
                    res.store_target = TGT_LTM;
                    res.store_index  = 8'd0;
                    res.store_byte   = b;
                    ltm_count_next   = 5'd0;
                    xor_sum_next     = 8'd0;
                end else begin
                    res.accepted = 1'b0;
                end
            end
        endcase
    end

    // Parser control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg         <= ST_IDLE;
            version_reg       <= MSP_V1;
            xor_sum_reg       <= 8'd0;
            crc_sum_reg       <= 8'd0;
            byte_offset_reg   <= 16'd0;
            expected_size_reg <= 16'd0;
            command_reg       <= 16'd0;
            flags_reg         <= 8'd0;
            ltm_kind_reg      <= LTM_KIND_A;
            ltm_count_reg     <= 5'd0;
        end else if (in_accept) begin
            state_reg         <= state_next;
            version_reg       <= version_next;
            xor_sum_reg       <= xor_sum_next;
            crc_sum_reg       <= crc_sum_next;
            byte_offset_reg   <= byte_offset_next;
            expected_size_reg <= expected_size_next;
            command_reg       <= command_next;
            flags_reg         <= flags_next;
            ltm_kind_reg      <= ltm_kind_next;
            ltm_count_reg     <= ltm_count_next;
        end
    end

    // Header byte store
    always_ff @(posedge clk)
    begin
        if (in_accept && hdr_we && (byte_offset_reg < 16'd6)) begin
            hdr_mem[byte_offset_reg[2:0]] <= b;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (in_accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            result_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0,
                            result_reg.ltm_frame_type,
                            result_reg.payload_size,
                            result_reg.cmd_flags,
                            result_reg.command,
                            result_reg.msp_version,
                            result_reg.frame_done,
                            result_reg.store_byte,
                            result_reg.store_index,
                            result_reg.store_valid,
                            result_reg.accepted};
    assign m_axis_tuser  = {result_reg.frame_kind, result_reg.store_target};

    // Checks
    a_done_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && res.frame_done |=> state_reg == ST_IDLE)
        else $error("parser not idle after a completed frame");

    a_msp_check_not_stored: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && res.frame_done && (res.frame_kind == TGT_MSP) |-> !res.store_valid)
        else $error("MSP check byte written to buffer");

    a_reject_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !res.accepted |-> state_reg == ST_IDLE)
        else $error("byte rejected outside idle");

    a_payload_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_V1_PAY || state_reg == ST_TUN_PAY || state_reg == ST_NAT_PAY)
        |-> (byte_offset_reg < expected_size_reg) && (expected_size_reg <= INBUF_SIZE))
        else $error("payload offset beyond frame size");

endmodule
